>>> src/assert_macros.svh
// Assertion helpers shared by the reservoir statistics modules.
// Depends on a clock named clk and an active-low reset named arst_n in the user module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, quiet while reset is applied.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

>>> src/lrs_pkg.sv
// Shared types and constants for the latency reservoir statistics block.
// No dependencies; imported by every module of the block except lrs_div.
package lrs_pkg;

	localparam int RESERVOIR_SIZE = 64;
	localparam int AW = (RESERVOIR_SIZE > 1) ? $clog2(RESERVOIR_SIZE) : 1;
	localparam int FILL_W = $clog2(RESERVOIR_SIZE + 1);
	localparam int FILLED_W = 7;
	localparam int QUEUE_DEPTH = 4;
	localparam int QAW = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] CMD_RECORD = 2'd0;
	localparam logic [1:0] CMD_QUERY  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] latency;
		logic [31:0] random_word;
	} item_t;

endpackage

>>> src/lrs_front.sv
// Front end: accepts commands, drops unused command codes and queues the rest.
// Depends on lrs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lrs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    command,
	input  logic [31:0]   latency,
	input  logic [31:0]   random_word,
	output logic          item_valid,
	output lrs_pkg::item_t item,
	input  logic          take
);
	import lrs_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QAW-1:0]    wr_q;
	logic [QAW-1:0]    rd_q;
	logic [QAW:0]      cnt_q;
	logic              enq;
	logic              deq;

	assign full = (cnt_q == (QAW+1)'(QUEUE_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item = mem_q[rd_q];
	// Unused command codes are accepted but never reach the back end.
	assign enq = push && !full && (command == CMD_RECORD || command == CMD_QUERY ||
		command == CMD_CLEAR);
	assign deq = take && item_valid;

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_q] <= '{command: command, latency: latency, random_word: random_word};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wr_q <= wr_q + 1'b1;
			end
			if (deq) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({enq, deq})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ASSERT_CLK(a_cnt_bound, cnt_q <= (QAW+1)'(QUEUE_DEPTH), "queue count over depth")
	`ASSERT_CLK(a_take_nonempty, take |-> item_valid, "back end took from an empty queue")
	`ASSERT_CLK(a_no_enq_full, full |-> !enq, "queue written while full")
endmodule

>>> src/lrs_div.sv
// Restoring divider, one quotient bit per cycle, for the 64-by-32 average.
// Depends on nothing but itself.
module lrs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	logic [31:0] rem_q;
	logic [63:0] q_q;
	logic [31:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [32:0] rem_sh;
	logic [32:0] diff;
	logic        ge;

	assign rem_sh = {rem_q, q_q[63]};
	assign diff = rem_sh - {1'b0, dvs_q};
	assign ge = !diff[32];
	assign quotient = q_q;
	assign done = busy_q && (cnt_q == 7'd0);

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q && cnt_q != 7'd0) begin
			rem_q <= ge ? diff[31:0] : rem_sh[31:0];
			q_q <= {q_q[62:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 7'd64;
		end else if (busy_q) begin
			if (cnt_q == 7'd0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

>>> src/lrs_back.sv
// Back end: statistics registers, reservoir memory, in-place insertion sort and result register.
// Depends on lrs_pkg, lrs_div and assert_macros.svh.
`include "assert_macros.svh"
module lrs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  lrs_pkg::item_t item,
	output logic           take,
	output logic           empty,
	input  logic           pop,
	output logic [31:0]    sample_count,
	output logic [31:0]    average,
	output logic [31:0]    median,
	output logic [6:0]     filled
);
	import lrs_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_REC_WR = 4'd1;
	localparam logic [3:0] ST_DIV    = 4'd2;
	localparam logic [3:0] ST_SORT   = 4'd3;
	localparam logic [3:0] ST_LD     = 4'd4;
	localparam logic [3:0] ST_V      = 4'd5;
	localparam logic [3:0] ST_CMP    = 4'd6;
	localparam logic [3:0] ST_INS    = 4'd7;
	localparam logic [3:0] ST_MED_A  = 4'd8;
	localparam logic [3:0] ST_MED_B  = 4'd9;
	localparam logic [3:0] ST_MED_C  = 4'd10;

	logic [3:0]        st_q;
	logic [63:0]       sum_q;
	logic [31:0]       count_q;
	logic [FILL_W-1:0] fill_q;
	logic [63:0]       prod_q;
	logic [31:0]       lat_q;
	logic [FILL_W-1:0] i_q;
	logic [AW-1:0]     j_q;
	logic [31:0]       v_q;
	logic [31:0]       m0_q;
	logic              out_valid_q;
	logic [31:0]       avg_q;
	logic [31:0]       med_q;
	logic [31:0]       count_res_q;
	logic [FILL_W-1:0] fill_res_q;

	logic [31:0]       res_mem [RESERVOIR_SIZE];
	logic [31:0]       rd_data;
	logic [AW-1:0]     ra;
	logic              we;
	logic [AW-1:0]     wa;
	logic [31:0]       wd;

	logic [31:0]       count_inc;
	logic [FILL_W-1:0] half;
	logic              div_start;
	logic              div_done;
	logic [63:0]       div_q;
	logic [32:0]       mid_sum;

	assign count_inc = (count_q == 32'hFFFF_FFFF) ? count_q : count_q + 32'd1;
	assign half = fill_q >> 1;
	assign mid_sum = {1'b0, m0_q} + {1'b0, rd_data};
	assign take = (st_q == ST_IDLE) && item_valid &&
		(item.command != CMD_QUERY || !out_valid_q);
	assign div_start = take && item.command == CMD_QUERY && count_q != '0;

	// The result fields are held as of the query while later records keep running.
	assign empty = !out_valid_q;
	assign sample_count = count_res_q;
	assign average = avg_q;
	assign median = med_q;
	assign filled = FILLED_W'(fill_res_q);

	lrs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// Memory address and write controls.
	always_comb begin
		ra = '0;
		we = 1'b0;
		wa = '0;
		wd = '0;
		unique case (st_q)
			ST_IDLE: begin
				if (take && item.command == CMD_RECORD &&
					fill_q < FILL_W'(RESERVOIR_SIZE)) begin
					we = 1'b1;
					wa = AW'(fill_q);
					wd = item.latency;
				end
			end
			ST_REC_WR: begin
				if (prod_q[63:32] < 32'(RESERVOIR_SIZE)) begin
					we = 1'b1;
					wa = AW'(prod_q[63:32]);
					wd = lat_q;
				end
			end
			ST_LD: ra = AW'(i_q);
			ST_V: ra = AW'(i_q - 1'b1);
			ST_CMP: begin
				ra = j_q - AW'(2);
				if (rd_data > v_q) begin
					we = 1'b1;
					wa = j_q;
					wd = rd_data;
				end
			end
			ST_INS: begin
				we = 1'b1;
				wa = j_q;
				wd = v_q;
			end
			ST_MED_A: ra = fill_q[0] ? AW'(half) : AW'(half - 1'b1);
			ST_MED_B: ra = AW'(half);
			default: ra = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			res_mem[wa] <= wd;
		end
		rd_data <= res_mem[ra];
	end

	always_ff @(posedge clk) begin
		if (take && item.command == CMD_RECORD) begin
			prod_q <= item.random_word * count_inc;
			lat_q <= item.latency;
		end
		if (st_q == ST_V) begin
			v_q <= rd_data;
		end
		if (st_q == ST_MED_B) begin
			m0_q <= rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			sum_q <= '0;
			count_q <= '0;
			fill_q <= '0;
			i_q <= '0;
			j_q <= '0;
			out_valid_q <= 1'b0;
			avg_q <= '0;
			med_q <= '0;
			count_res_q <= '0;
			fill_res_q <= '0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (take) begin
						unique case (item.command)
							CMD_RECORD: begin
								sum_q <= sum_q + 64'(item.latency);
								count_q <= count_inc;
								if (fill_q < FILL_W'(RESERVOIR_SIZE)) begin
									fill_q <= fill_q + 1'b1;
								end else begin
									st_q <= ST_REC_WR;
								end
							end
							CMD_QUERY: begin
								if (count_q == '0) begin
									avg_q <= '0;
									st_q <= ST_SORT;
								end else begin
									st_q <= ST_DIV;
								end
							end
							default: begin
								sum_q <= '0;
								count_q <= '0;
								fill_q <= '0;
							end
						endcase
					end
				end
				ST_REC_WR: st_q <= ST_IDLE;
				ST_DIV: begin
					if (div_done) begin
						avg_q <= (div_q[63:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
						st_q <= ST_SORT;
					end
				end
				ST_SORT: begin
					i_q <= FILL_W'(1);
					st_q <= (fill_q > FILL_W'(1)) ? ST_LD : ST_MED_A;
				end
				ST_LD: st_q <= ST_V;
				ST_V: begin
					j_q <= AW'(i_q);
					st_q <= ST_CMP;
				end
				ST_CMP: begin
					if (rd_data > v_q) begin
						j_q <= j_q - 1'b1;
						if (j_q == AW'(1)) begin
							st_q <= ST_INS;
						end
					end else begin
						st_q <= ST_INS;
					end
				end
				ST_INS: begin
					i_q <= i_q + 1'b1;
					st_q <= (i_q + 1'b1 == fill_q) ? ST_MED_A : ST_LD;
				end
				ST_MED_A: begin
					if (fill_q == '0) begin
						med_q <= '0;
						count_res_q <= count_q;
						fill_res_q <= fill_q;
						out_valid_q <= 1'b1;
						st_q <= ST_IDLE;
					end else begin
						st_q <= ST_MED_B;
					end
				end
				ST_MED_B: st_q <= ST_MED_C;
				ST_MED_C: begin
					med_q <= fill_q[0] ? m0_q : mid_sum[32:1];
					count_res_q <= count_q;
					fill_res_q <= fill_q;
					out_valid_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_CLK(a_fill_bound, fill_q <= FILL_W'(RESERVOIR_SIZE), "fill level over size")
	`ASSERT_CLK(a_cmp_index, st_q == ST_CMP |-> j_q != '0, "sort compare at slot zero")
	`ASSERT_CLK(a_div_done, div_done |-> st_q == ST_DIV, "divider finished outside query")
endmodule

>>> src/latency_reservoir_stats_top.sv
// Top level of the latency reservoir statistics block.
// Depends on lrs_pkg, lrs_front, lrs_back (which holds lrs_div) and assert_macros.svh.
//
// This block keeps running latency statistics: a wrapping 64-bit sum, a
// saturating 32-bit sample count and a 64-entry reservoir sample kept with
// Algorithm R. Commands arrive through a queue-style port (push/full) and go
// into a four-entry command queue, so the sender can keep pushing while the
// back end is busy; unused command codes are taken and dropped. A record is
// done in the idle state while the reservoir is filling; once it is full, a
// 32x32 multiply for the replacement slot is registered and the memory
// write follows in ST_REC_WR. A clear is done in the idle state. A query
// runs a one-bit-per-cycle divider for the average when the count is
// nonzero, then an insertion sort of the reservoir in place on the memory,
// which has one read and one write port (states ST_LD, ST_V, ST_CMP and
// ST_INS), and then reads the median in ST_MED_A to ST_MED_C. The query
// result, with the count and fill level as they stood at the query, waits
// in an output register that is read with empty/pop; a second query waits
// at the head of the command queue, holding back the commands behind it,
// until that result has been transferred. Reservoir contents are undefined
// after reset, but only slots written since the last clear are ever read.
module latency_reservoir_stats_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [31:0] latency,
	input  logic [31:0] random_word,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] sample_count,
	output logic [31:0] average,
	output logic [31:0] median,
	output logic [6:0]  filled
);
	import lrs_pkg::*;

	// Handshake between the command queue and the execution back end.
	logic  item_valid;
	item_t item;
	logic  take;

	lrs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.command     (command),
		.latency     (latency),
		.random_word (random_word),
		.item_valid  (item_valid),
		.item        (item),
		.take        (take)
	);

	lrs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item         (item),
		.take         (take),
		.empty        (empty),
		.pop          (pop),
		.sample_count (sample_count),
		.average      (average),
		.median       (median),
		.filled       (filled)
	);
endmodule

>>> verif/latency_reservoir_stats_top_tb.sv
// Self-checking testbench for latency_reservoir_stats_top: records, queries, clears, ignored codes.
// Depends on lrs_pkg and the block's RTL; it predicts every query result internally.
module latency_reservoir_stats_top_tb;
	import lrs_pkg::*;

	// This code is never decoded by the block. It is taken and dropped.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// A query result that is expected from the block.
	typedef struct {
		logic [31:0] sample_count;
		logic [31:0] average;
		logic [31:0] median;
		logic [6:0]  filled;
	} stats_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  command;
	logic [31:0] latency;
	logic [31:0] random_word;
	logic        empty;
	logic        pop;
	logic [31:0] sample_count;
	logic [31:0] average;
	logic [31:0] median;
	logic [6:0]  filled;

	latency_reservoir_stats_top DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.command(command), .latency(latency), .random_word(random_word),
		.empty(empty), .pop(pop), .sample_count(sample_count),
		.average(average), .median(median), .filled(filled)
	);

	// This is the testbench's own copy of the statistics state.
	logic [63:0] sum_model;
	logic [31:0] count_model;
	int          fill_model;
	logic [31:0] samples_model [RESERVOIR_SIZE];

	stats_t pending_stats [$];
	int     mismatches;
	int     items_sent;
	int     queries_checked;
	int     replacements_dropped;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The limit is taken from the worst case: every random item a query that sorts a full,
	// scrambled reservoir, added to the longest stalls on both sides.
	initial begin
		#400_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		mismatches++;
	endtask

	// This sorts the filled part of the reservoir in place, as the block leaves it after a
	// query, and then returns the middle value, or the floor of the mean of the two middle ones.
	function automatic logic [31:0] reservoir_median();
		logic [31:0] v;
		logic [32:0] pair_sum;
		int j;
		if (fill_model == 0)
			return 32'd0;
		for (int i = 1; i < fill_model; i++) begin
			v = samples_model[i];
			j = i;
			while (j > 0 && samples_model[j - 1] > v) begin
				samples_model[j] = samples_model[j - 1];
				j--;
			end
			samples_model[j] = v;
		end
		if (fill_model % 2 == 0) begin
			pair_sum = {1'b0, samples_model[fill_model / 2 - 1]}
				+ {1'b0, samples_model[fill_model / 2]};
			return pair_sum[32:1];
		end
		return samples_model[fill_model / 2];
	endfunction

	// This updates the statistics state for one accepted command and queues any result.
	task automatic apply_command(input logic [1:0] cmd, input logic [31:0] lat,
			input logic [31:0] rnd);
		logic [63:0] slot;
		logic [63:0] avg;
		stats_t s;
		case (cmd)
			CMD_RECORD: begin
				sum_model += {32'd0, lat};
				if (count_model != 32'hFFFF_FFFF)
					count_model++;
				if (fill_model < RESERVOIR_SIZE) begin
					samples_model[fill_model] = lat;
					fill_model++;
				end else begin
					// Algorithm R picks the slot with the new count. It can fall past the end.
					slot = ({32'd0, rnd} * {32'd0, count_model}) >> 32;
					if (slot < RESERVOIR_SIZE)
						samples_model[slot] = lat;
					else
						replacements_dropped++;
				end
			end
			CMD_CLEAR: begin
				sum_model = '0;
				count_model = '0;
				fill_model = 0;
			end
			CMD_QUERY: begin
				avg = '0;
				if (count_model != 0) begin
					avg = sum_model / {32'd0, count_model};
					if (avg > 64'hFFFF_FFFF)
						avg = 64'hFFFF_FFFF;
				end
				s.sample_count = count_model;
				s.average = avg[31:0];
				s.median = reservoir_median();
				s.filled = fill_model[6:0];
				pending_stats.push_back(s);
			end
			default: ;
		endcase
	endtask

	// This sends one command. The task is entered at a falling edge and returns at one.
	// Push stays high from one item to the next inside a burst. It only drops during a gap.
	task automatic send_item(input logic [1:0] cmd, input logic [31:0] lat,
			input logic [31:0] rnd, input int gap);
		command <= cmd;
		latency <= lat;
		random_word <= rnd;
		push <= 1'b1;
		do
			@(posedge clk);
		while (full);
		apply_command(cmd, lat, rnd);
		items_sent++;
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// The sender holds off until every expected query result has been transferred.
	task automatic wait_drained();
		push <= 1'b0;
		while (pending_stats.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// A query with no samples recorded must report zero for everything.
	task automatic test_empty_query();
		send_item(CMD_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_item(CMD_UNUSED, 32'h1234_5678, 32'h0, 1);
		send_item(CMD_QUERY, 32'h0, 32'h0, 2);
	endtask

	// The field extremes are checked here. Two maximum values give an even median whose pair
	// sum needs 33 bits. An odd fill is also covered, as is a clear followed by a query.
	task automatic test_extremes();
		send_item(CMD_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_item(CMD_RECORD, 32'hFFFF_FFFF, 32'h0, 0);
		send_item(CMD_QUERY, 32'h0, 32'h0, 0);
		send_item(CMD_RECORD, 32'h0, 32'h0, 0);
		send_item(CMD_QUERY, 32'h0, 32'h0, 3);
		send_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_item(CMD_QUERY, 32'h0, 32'h0, 0);
		send_item(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_item(CMD_QUERY, 32'h0, 32'h0, 0);
	endtask

	// This fills the reservoir to the end. It then replaces one sample with a low random
	// word, drops one because the slot falls outside with a high random word, and queries.
	task automatic test_fill_and_replace();
		for (int i = 0; i < RESERVOIR_SIZE; i++)
			send_item(CMD_RECORD, $urandom(), $urandom(), 0);
		send_item(CMD_QUERY, 32'h0, 32'h0, 0);
		send_item(CMD_RECORD, 32'h0, 32'h0000_0001, 0);
		send_item(CMD_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_item(CMD_QUERY, 32'h0, 32'h0, 0);
		wait_drained();
	endtask

	// The random traffic is mostly records, with scattered queries, rare clears and some
	// unused codes. It runs in bursts with gaps. Latencies vary in range so that the sums
	// stay interesting. Random words are sometimes small so that replacements hit often.
	task automatic test_random(input int n);
		logic [1:0]  cmd;
		logic [31:0] lat;
		logic [31:0] rnd;
		int burst;
		int k;
		int gap;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			cmd = (k < 80) ? CMD_RECORD : (k < 89) ? CMD_QUERY :
				(k < 92) ? CMD_CLEAR : CMD_UNUSED;
			case ($urandom_range(0, 3))
				0: lat = $urandom_range(0, 255);
				1: lat = $urandom_range(0, 100000);
				2: lat = 32'hFFFF_FFFF - $urandom_range(0, 15);
				default: lat = $urandom();
			endcase
			rnd = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h00FF_FFFF);
			if (burst == 0) begin
				burst = $urandom_range(1, 30);
				gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			end else
				gap = 0;
			burst--;
			if (burst != 0)
				gap = 0;
			send_item(cmd, lat, rnd, gap);
			if (i == n / 2)
				wait_drained();
		end
	endtask

	// The receiver switches at random between stall patterns. The patterns are always
	// ready, a coin toss, or rare pops that leave results waiting a long time.
	initial begin
		int mode;
		int cyc;
		pop = 1'b0;
		mode = 0;
		cyc = 0;
		forever begin
			@(negedge clk);
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 2);
			cyc++;
			case (mode)
				0: pop <= 1'b1;
				1: pop <= $urandom_range(0, 1);
				default: pop <= ($urandom_range(0, 15) == 0);
			endcase
		end
	end

	// Each result is compared with the oldest outstanding query when its transfer happens.
	always @(posedge clk) begin
		stats_t w;
		if (arst_n && pop && !empty) begin
			if (pending_stats.size() == 0) begin
				$display("result transfer with no query outstanding");
				mismatches++;
			end else begin
				w = pending_stats.pop_front();
				queries_checked++;
				if (sample_count !== w.sample_count)
					report("sample_count", sample_count, w.sample_count);
				if (average !== w.average)
					report("average", average, w.average);
				if (median !== w.median)
					report("median", median, w.median);
				if (filled !== w.filled)
					report("filled", {25'd0, filled}, {25'd0, w.filled});
			end
		end
	end

	initial begin
		sum_model = '0;
		count_model = '0;
		fill_model = 0;
		foreach (samples_model[i])
			samples_model[i] = '0;
		mismatches = 0;
		items_sent = 0;
		queries_checked = 0;
		replacements_dropped = 0;
		arst_n = 1'b0;
		push = 1'b0;
		command = CMD_RECORD;
		latency = '0;
		random_word = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_query();
		test_extremes();
		test_fill_and_replace();
		test_random(570);

		wait_drained();
		repeat (200) @(negedge clk);
		if (pending_stats.size() != 0) begin
			$display("%0d query results never arrived", pending_stats.size());
			mismatches++;
		end
		$display("Sent %0d commands and checked %0d query results.", items_sent,
			queries_checked);
		$display("Full reservoir and %0d dropped replacements covered; %0d mismatches.",
			replacements_dropped, mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
